// ----- rtl/core/fpve_pkg.sv -----
// ----------------------------------------------------------------------------
// fpve_pkg
// Shared types, constants and helpers for the filtered pose velocity
// estimator: request and response payloads, register indexes, sequencer
// states and the quaternion product term table.
// ----------------------------------------------------------------------------
package fpve_pkg;

   // request payload, first member is the most significant
   typedef struct packed {
      logic [47:0]        time_us;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] quat_w;
      logic signed [31:0] quat_x;
      logic signed [31:0] quat_y;
      logic signed [31:0] quat_z;
   } req_type;

   // response payload
   typedef struct packed {
      logic [47:0]        out_time_us;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic signed [31:0] rate_x;
      logic signed [31:0] rate_y;
      logic signed [31:0] rate_z;
      logic               fresh;
   } rsp_type;

   // register indexes
   localparam logic [1:0] REG_K_VEL   = 2'd0;
   localparam logic [1:0] REG_K_RATE  = 2'd1;
   localparam logic [1:0] REG_MIN_GAP = 2'd2;
   localparam logic [1:0] REG_MAX_GAP = 2'd3;

   localparam logic [23:0] MIN_GAP_RESET = 24'd100;
   localparam logic [23:0] MAX_GAP_RESET = 24'd2000000;

   // 1e6 = 15625 << 6 and 2e6 = 15625 << 7
   localparam int unsigned SCALE_ODD = 15625;
   localparam int unsigned VEL_SHIFT = 6;
   localparam int unsigned RATE_SHIFT = 7;

   // divider sizes
   localparam int unsigned DVD_W = 60;
   localparam int unsigned DVS_W = 40;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_GAP,
      ST_CHECK,
      ST_VMUL,
      ST_QMUL,
      ST_QACC,
      ST_SMUL,
      ST_DSTART,
      ST_DWAIT,
      ST_BMUL,
      ST_BEND,
      ST_STORE
   } state_type;

   // one product term of conj(q_old) * q_new
   typedef struct packed {
      logic [1:0] a_sel;
      logic [1:0] b_sel;
      logic       neg;
   } term_type;

   function automatic term_type term_lookup(input logic [3:0] idx);
      term_type t;
      unique case (idx)
         4'd0:    t = '{2'd0, 2'd1, 1'b0};
         4'd1:    t = '{2'd1, 2'd0, 1'b1};
         4'd2:    t = '{2'd2, 2'd3, 1'b1};
         4'd3:    t = '{2'd3, 2'd2, 1'b0};
         4'd4:    t = '{2'd0, 2'd2, 1'b0};
         4'd5:    t = '{2'd1, 2'd3, 1'b0};
         4'd6:    t = '{2'd2, 2'd0, 1'b1};
         4'd7:    t = '{2'd3, 2'd1, 1'b1};
         4'd8:    t = '{2'd0, 2'd3, 1'b0};
         4'd9:    t = '{2'd1, 2'd2, 1'b1};
         4'd10:   t = '{2'd2, 2'd1, 1'b0};
         4'd11:   t = '{2'd3, 2'd0, 1'b1};
         default: t = '{2'd0, 2'd0, 1'b0};
      endcase
      return t;
   endfunction

   // sign and magnitude to saturated 32 bit two's complement
   function automatic logic [31:0] sat_mag(input logic neg, input logic [59:0] mag);
      logic [31:0] r;
      if (!neg) begin
         r = (mag > 60'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
      end else begin
         r = (mag > 60'h0_8000_0000) ? 32'h8000_0000 : 32'(~mag[31:0] + 32'd1);
      end
      return r;
   endfunction

endpackage

// ----- rtl/core/filtered_pose_velocity_estimator_core.sv -----
// ----------------------------------------------------------------------------
// filtered_pose_velocity_estimator_core
// Finite difference velocity and quaternion rate estimator with first order
// low-pass filtering, built around one shared multiplier and one divider.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  fpve_pkg::req_type
//   rsp      out        rsp_valid/rsp_ready  fpve_pkg::rsp_type
//   csr      in         csr_valid/csr_ready  csr_index, csr_data
//
// A rejected request goes from the check step straight to the store step; an
// accepted one runs six divisions through the shared divider, plus twelve
// quaternion products and six blends through the shared multiplier.
// Synchronous reset clears all filter state and loads the register defaults.
// req_ready is high only while the sequencer idles; a result waiting on
// rsp_ready stalls the next request only at its final store step.
// ----------------------------------------------------------------------------
module filtered_pose_velocity_estimator_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  fpve_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output fpve_pkg::rsp_type  rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [23:0]        csr_data
);

   fpve_pkg::state_type state_ff, state_in;

   logic [15:0] k_vel_ff, k_rate_ff;
   logic [23:0] min_gap_ff, max_gap_ff;

   fpve_pkg::req_type  in_ff;
   fpve_pkg::rsp_type  rsp_ff;
   logic               rsp_valid_ff;

   logic [47:0]        prev_time_ff;
   logic signed [31:0] prev_pos_ff [3];
   logic signed [31:0] prev_q_ff [4];
   logic signed [31:0] filt_ff [6];
   logic signed [31:0] d_ff [6];
   logic [47:0]        filt_time_ff;
   logic               primed_ff;

   logic [48:0]        gap_ff;
   logic               nz_ff;
   logic               ok_ff;
   logic [2:0]         idx_ff;
   logic [1:0]         k_ff;
   logic signed [36:0] s_ff;
   logic signed [70:0] prod_ff;
   logic               dneg_ff;

   logic signed [31:0] cur_pos [3];
   logic signed [31:0] cur_q [4];

   logic signed [37:0] mul_a;
   logic signed [32:0] mul_b;
   logic signed [70:0] mul_p;

   logic                         div_start;
   logic                         div_done;
   logic [fpve_pkg::DVD_W-1:0]   div_dvd;
   logic [fpve_pkg::DVS_W-1:0]   div_dvs;
   logic [fpve_pkg::DVD_W-1:0]   div_q;

   fpve_pkg::term_type term;
   logic [70:0]        prod_mag;
   logic [34:0]        qm;
   logic               qneg;
   logic signed [32:0] vel_dp;
   logic signed [32:0] bdiff;
   logic [16:0]        wk;
   logic signed [50:0] bnum;
   logic [50:0]        bmag;
   logic [51:0]        bsum;
   logic [31:0]        bres;
   logic [23:0]        gap24;
   logic               ok_calc;
   logic               store_go;
   logic               req_take;

   assign cur_pos[0] = in_ff.pos_x;
   assign cur_pos[1] = in_ff.pos_y;
   assign cur_pos[2] = in_ff.pos_z;
   assign cur_q[0]   = in_ff.quat_w;
   assign cur_q[1]   = in_ff.quat_x;
   assign cur_q[2]   = in_ff.quat_y;
   assign cur_q[3]   = in_ff.quat_z;

   assign gap24     = gap_ff[23:0];
   assign req_ready = (state_ff == fpve_pkg::ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign store_go  = (state_ff == fpve_pkg::ST_STORE) && (!rsp_valid_ff || rsp_ready);
   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         k_vel_ff   <= '0;
         k_rate_ff  <= '0;
         min_gap_ff <= fpve_pkg::MIN_GAP_RESET;
         max_gap_ff <= fpve_pkg::MAX_GAP_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            fpve_pkg::REG_K_VEL:   k_vel_ff   <= csr_data[15:0];
            fpve_pkg::REG_K_RATE:  k_rate_ff  <= csr_data[15:0];
            fpve_pkg::REG_MIN_GAP: min_gap_ff <= csr_data;
            fpve_pkg::REG_MAX_GAP: max_gap_ff <= csr_data;
         endcase
      end
   end

   // shared multiplier operand selection
   assign term   = fpve_pkg::term_lookup({2'(idx_ff - 3'd3), k_ff});
   assign vel_dp = 33'(cur_pos[idx_ff[1:0]]) - 33'(prev_pos_ff[idx_ff[1:0]]);
   assign bdiff  = 33'(d_ff[idx_ff]) - 33'(filt_ff[idx_ff]);
   assign wk     = 17'(17'h10000 - {1'b0, (idx_ff < 3'd3) ? k_vel_ff : k_rate_ff});

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         fpve_pkg::ST_VMUL: begin
            mul_a = 38'(vel_dp);
            mul_b = 33'(fpve_pkg::SCALE_ODD);
         end
         fpve_pkg::ST_QMUL: begin
            mul_a = 38'(prev_q_ff[term.a_sel]);
            mul_b = 33'(cur_q[term.b_sel]);
         end
         fpve_pkg::ST_SMUL: begin
            mul_a = 38'(s_ff);
            mul_b = 33'(fpve_pkg::SCALE_ODD);
         end
         fpve_pkg::ST_BMUL: begin
            mul_a = 38'(bdiff);
            mul_b = {16'b0, wk};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // product magnitude, quaternion term truncated toward zero
   assign prod_mag = prod_ff[70] ? 71'(-prod_ff) : 71'(prod_ff);
   assign qm       = prod_mag[62:28];
   assign qneg     = prod_ff[70] ^ term.neg;

   // divider operands: velocity or rate scaling with half-divisor rounding
   always_comb begin
      if (idx_ff < 3'd3) begin
         div_dvd = 60'(prod_mag << fpve_pkg::VEL_SHIFT) + 60'(gap24 >> 1);
         div_dvs = 40'(gap24);
      end else begin
         div_dvd = 60'(prod_mag << fpve_pkg::RATE_SHIFT) + 60'({gap24, 15'b0});
         div_dvs = {gap24, 16'b0};
      end
   end

   assign div_start = (state_ff == fpve_pkg::ST_DSTART);

   fpve_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .done     (div_done),
      .quotient (div_q)
   );

   // blend: old * 65536 + (65536 - k) * (d - old), rounded by 2^16
   assign bnum = {{3{filt_ff[idx_ff][31]}}, filt_ff[idx_ff], 16'b0} + prod_ff[50:0];
   assign bmag = bnum[50] ? 51'(-bnum) : 51'(bnum);
   assign bsum = {1'b0, bmag} + 52'd32768;
   assign bres = fpve_pkg::sat_mag(bnum[50], 60'(bsum[51:16]));

   // gap acceptance
   assign ok_calc = nz_ff && !gap_ff[48] && (gap_ff[47:0] != 48'd0)
                 && (gap_ff[47:0] >= {24'b0, min_gap_ff})
                 && (gap_ff[47:0] <= {24'b0, max_gap_ff});

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fpve_pkg::ST_IDLE:   if (req_take) state_in = fpve_pkg::ST_GAP;
         fpve_pkg::ST_GAP:    state_in = fpve_pkg::ST_CHECK;
         fpve_pkg::ST_CHECK:  state_in = ok_calc ? fpve_pkg::ST_VMUL : fpve_pkg::ST_STORE;
         fpve_pkg::ST_VMUL:   state_in = fpve_pkg::ST_DSTART;
         fpve_pkg::ST_QMUL:   state_in = fpve_pkg::ST_QACC;
         fpve_pkg::ST_QACC:   state_in = (k_ff == 2'd3) ? fpve_pkg::ST_SMUL : fpve_pkg::ST_QMUL;
         fpve_pkg::ST_SMUL:   state_in = fpve_pkg::ST_DSTART;
         fpve_pkg::ST_DSTART: state_in = fpve_pkg::ST_DWAIT;
         fpve_pkg::ST_DWAIT: begin
            if (div_done) begin
               priority if (idx_ff == 3'd5) state_in = fpve_pkg::ST_BMUL;
               else if (idx_ff < 3'd2)      state_in = fpve_pkg::ST_VMUL;
               else                         state_in = fpve_pkg::ST_QMUL;
            end
         end
         fpve_pkg::ST_BMUL:   state_in = fpve_pkg::ST_BEND;
         fpve_pkg::ST_BEND:   state_in = (idx_ff == 3'd5) ? fpve_pkg::ST_STORE : fpve_pkg::ST_BMUL;
         fpve_pkg::ST_STORE:  if (store_go) state_in = fpve_pkg::ST_IDLE;
         default:             state_in = fpve_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fpve_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // working registers of one request
   always_ff @(posedge clock) begin
      prod_ff <= mul_p;
      if (req_take) begin
         in_ff <= req_data;
      end
      if (state_ff == fpve_pkg::ST_GAP) begin
         gap_ff <= {1'b0, in_ff.time_us} - {1'b0, prev_time_ff};
         nz_ff  <= (prev_time_ff != 48'd0);
      end
      if (state_ff == fpve_pkg::ST_CHECK) begin
         ok_ff  <= ok_calc;
         idx_ff <= 3'd0;
      end
      if (state_ff == fpve_pkg::ST_DSTART) begin
         dneg_ff <= prod_ff[70];
      end
      if (state_ff == fpve_pkg::ST_DWAIT && div_done) begin
         d_ff[idx_ff] <= fpve_pkg::sat_mag(dneg_ff, div_q);
         idx_ff       <= (idx_ff == 3'd5) ? 3'd0 : idx_ff + 3'd1;
         k_ff         <= 2'd0;
         s_ff         <= '0;
      end
      if (state_ff == fpve_pkg::ST_QACC) begin
         s_ff <= qneg ? s_ff - 37'(qm) : s_ff + 37'(qm);
         k_ff <= k_ff + 2'd1;
      end
      if (state_ff == fpve_pkg::ST_BEND) begin
         idx_ff <= idx_ff + 3'd1;
      end
   end

   // filter and pose state
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_time_ff <= '0;
         filt_time_ff <= '0;
         primed_ff    <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            prev_pos_ff[i] <= '0;
         end
         for (int i = 0; i < 4; i++) begin
            prev_q_ff[i] <= '0;
         end
         for (int i = 0; i < 6; i++) begin
            filt_ff[i] <= '0;
         end
      end else begin
         if (state_ff == fpve_pkg::ST_BEND) begin
            filt_ff[idx_ff] <= primed_ff ? bres : d_ff[idx_ff];
         end
         if (store_go) begin
            prev_time_ff <= in_ff.time_us;
            for (int i = 0; i < 3; i++) begin
               prev_pos_ff[i] <= cur_pos[i];
            end
            for (int i = 0; i < 4; i++) begin
               prev_q_ff[i] <= cur_q[i];
            end
            if (ok_ff) begin
               filt_time_ff <= in_ff.time_us;
               primed_ff    <= 1'b1;
            end
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (store_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (store_go) begin
         rsp_ff.out_time_us <= ok_ff ? in_ff.time_us : filt_time_ff;
         rsp_ff.vel_x       <= filt_ff[0];
         rsp_ff.vel_y       <= filt_ff[1];
         rsp_ff.vel_z       <= filt_ff[2];
         rsp_ff.rate_x      <= filt_ff[3];
         rsp_ff.rate_y      <= filt_ff[4];
         rsp_ff.rate_z      <= filt_ff[5];
         rsp_ff.fresh       <= ok_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // divider is only started while the sequencer is not waiting on it
   a_div_start: assert property (@(posedge clock) disable iff (reset)
      div_start |=> (state_ff == fpve_pkg::ST_DWAIT) && !div_done)
      else $error("divider restarted while in use");

   // a rejected request leaves the filter time alone
   a_reject_time: assert property (@(posedge clock) disable iff (reset)
      (store_go && !ok_ff) |=> $stable(filt_time_ff))
      else $error("filter time moved on a rejected request");

   // an accepted difference leaves the filter primed
   a_primed: assert property (@(posedge clock) disable iff (reset)
      (store_go && ok_ff) |=> primed_ff && rsp_valid_ff && rsp_ff.fresh)
      else $error("fresh result without primed filter");

endmodule

// ----- rtl/core/fpve_div.sv -----
// ----------------------------------------------------------------------------
// fpve_div
// Unsigned restoring divider, one quotient bit per cycle. Start loads the
// operands, done pulses for one cycle when the quotient is ready.
// ----------------------------------------------------------------------------
module fpve_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [fpve_pkg::DVD_W-1:0]   dividend,
   input  logic [fpve_pkg::DVS_W-1:0]   divisor,
   output logic                         done,
   output logic [fpve_pkg::DVD_W-1:0]   quotient
);

   logic [fpve_pkg::DVS_W-1:0] rem_ff, rem_in;
   logic [fpve_pkg::DVD_W-1:0] dvd_ff, dvd_in;
   logic [fpve_pkg::DVS_W-1:0] dvs_ff;
   logic [5:0]                 cnt_ff, cnt_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [fpve_pkg::DVS_W+1:0] trial;

   // one restoring step
   always_comb begin
      trial   = {1'b0, rem_ff, dvd_ff[fpve_pkg::DVD_W-1]} - {2'b00, dvs_ff};
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         dvd_in  = dividend;
         cnt_in  = 6'(fpve_pkg::DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[fpve_pkg::DVS_W+1]) begin
            rem_in = trial[fpve_pkg::DVS_W-1:0];
         end else begin
            rem_in = {rem_ff[fpve_pkg::DVS_W-2:0], dvd_ff[fpve_pkg::DVD_W-1]};
         end
         dvd_in = {dvd_ff[fpve_pkg::DVD_W-2:0], ~trial[fpve_pkg::DVS_W+1]};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // operand and partial remainder registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      if (start) begin
         dvs_ff <= divisor;
      end
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

// ----- sim/fpve_checker.sv -----
// ----------------------------------------------------------------------------
// fpve_checker
// Watches the request, response and register channels of the pose velocity
// estimator, predicts each response from the accepted requests and the
// register writes seen, and compares the responses field by field.
// ----------------------------------------------------------------------------
module fpve_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  fpve_pkg::req_type  req_data,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  fpve_pkg::rsp_type  rsp_data,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [23:0]        csr_data,
   output int                 fail_count,
   output int                 pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   // estimator state as predicted
   logic [15:0]        k_vel, k_rate;
   logic [23:0]        min_gap, max_gap;
   logic [47:0]        last_time, held_time;
   longint             last_pos [3];
   longint             last_quat [4];
   longint             held_vel [3];
   longint             held_rate [3];
   bit                 primed;
   fpve_pkg::rsp_type  expected_rsp [$];

   assign pending_count = expected_rsp.size();

   function automatic longint clamp32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // nearest, ties away from zero
   function automatic longint round_div(input longint num, input longint den);
      longint m;
      m = (num < 0) ? -num : num;
      m = (m + den / 2) / den;
      return (num < 0) ? -m : m;
   endfunction

   // Q2.30 product truncated toward zero to Q.32
   function automatic longint quat_prod(input longint a, input longint b);
      longint p, m;
      p = a * b;
      m = ((p < 0) ? -p : p) >>> 28;
      return (p < 0) ? -m : m;
   endfunction

   function automatic longint iir(input longint k, input longint old, input longint d);
      return clamp32(round_div(k * old + (65536 - k) * d, 65536));
   endfunction

   function automatic fpve_pkg::rsp_type predict_pose(input fpve_pkg::req_type r);
      fpve_pkg::rsp_type o;
      longint  p [3], q [4], dv [3], dr [3], s [3], gap;
      bit      ok;
      p[0] = r.pos_x;  p[1] = r.pos_y;  p[2] = r.pos_z;
      q[0] = r.quat_w; q[1] = r.quat_x; q[2] = r.quat_y; q[3] = r.quat_z;
      gap = longint'(r.time_us) - longint'(last_time);
      ok = last_time != 0 && r.time_us > last_time && gap >= min_gap && gap <= max_gap;
      if (ok) begin
         for (int i = 0; i < 3; i++)
            dv[i] = clamp32(round_div((p[i] - last_pos[i]) * 1000000, gap));
         s[0] = quat_prod(last_quat[0], q[1]) - quat_prod(last_quat[1], q[0])
              - quat_prod(last_quat[2], q[3]) + quat_prod(last_quat[3], q[2]);
         s[1] = quat_prod(last_quat[0], q[2]) + quat_prod(last_quat[1], q[3])
              - quat_prod(last_quat[2], q[0]) - quat_prod(last_quat[3], q[1]);
         s[2] = quat_prod(last_quat[0], q[3]) - quat_prod(last_quat[1], q[2])
              + quat_prod(last_quat[2], q[1]) - quat_prod(last_quat[3], q[0]);
         for (int i = 0; i < 3; i++)
            dr[i] = clamp32(round_div(s[i] * 2000000, gap << 16));
         for (int i = 0; i < 3; i++) begin
            held_vel[i]  = primed ? iir(k_vel, held_vel[i], dv[i]) : dv[i];
            held_rate[i] = primed ? iir(k_rate, held_rate[i], dr[i]) : dr[i];
         end
         primed = 1;
         held_time = r.time_us;
      end
      last_time = r.time_us;
      for (int i = 0; i < 3; i++) last_pos[i] = p[i];
      for (int i = 0; i < 4; i++) last_quat[i] = q[i];
      o.out_time_us = held_time;
      o.vel_x  = held_vel[0][31:0];  o.vel_y  = held_vel[1][31:0];
      o.vel_z  = held_vel[2][31:0];
      o.rate_x = held_rate[0][31:0]; o.rate_y = held_rate[1][31:0];
      o.rate_z = held_rate[2][31:0];
      o.fresh  = ok;
      return o;
   endfunction

   // watch the three channels
   always @(posedge clock) begin
      fpve_pkg::rsp_type e;
      if (reset) begin
         k_vel = 0; k_rate = 0;
         min_gap = fpve_pkg::MIN_GAP_RESET; max_gap = fpve_pkg::MAX_GAP_RESET;
         last_time = 0; held_time = 0; primed = 0;
         for (int i = 0; i < 3; i++) begin
            last_pos[i] = 0; held_vel[i] = 0; held_rate[i] = 0;
         end
         for (int i = 0; i < 4; i++) last_quat[i] = 0;
         expected_rsp.delete();
         fail_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               fpve_pkg::REG_K_VEL:   k_vel = csr_data[15:0];
               fpve_pkg::REG_K_RATE:  k_rate = csr_data[15:0];
               fpve_pkg::REG_MIN_GAP: min_gap = csr_data;
               fpve_pkg::REG_MAX_GAP: max_gap = csr_data;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               $error("response with no request outstanding");
               fail_count++;
            end else begin
               e = expected_rsp.pop_front();
               if (rsp_data.out_time_us !== e.out_time_us) begin
                  $error("out_time_us: expected %0d, got %0d", e.out_time_us,
                         rsp_data.out_time_us);
                  fail_count++;
               end
               if (rsp_data.vel_x !== e.vel_x) begin
                  $error("vel_x: expected %0d, got %0d", e.vel_x, rsp_data.vel_x);
                  fail_count++;
               end
               if (rsp_data.vel_y !== e.vel_y) begin
                  $error("vel_y: expected %0d, got %0d", e.vel_y, rsp_data.vel_y);
                  fail_count++;
               end
               if (rsp_data.vel_z !== e.vel_z) begin
                  $error("vel_z: expected %0d, got %0d", e.vel_z, rsp_data.vel_z);
                  fail_count++;
               end
               if (rsp_data.rate_x !== e.rate_x) begin
                  $error("rate_x: expected %0d, got %0d", e.rate_x, rsp_data.rate_x);
                  fail_count++;
               end
               if (rsp_data.rate_y !== e.rate_y) begin
                  $error("rate_y: expected %0d, got %0d", e.rate_y, rsp_data.rate_y);
                  fail_count++;
               end
               if (rsp_data.rate_z !== e.rate_z) begin
                  $error("rate_z: expected %0d, got %0d", e.rate_z, rsp_data.rate_z);
                  fail_count++;
               end
               if (rsp_data.fresh !== e.fresh) begin
                  $error("fresh: expected %0d, got %0d", e.fresh, rsp_data.fresh);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) expected_rsp.push_back(predict_pose(req_data));
      end
   end

endmodule

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Stimulus for the pose velocity estimator: directed poses covering rejected
// gaps, first load, saturation and extreme quaternions, then random pose
// tracks under several filter and gap settings with random stalls on both
// sides. Checking is done by fpve_checker.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT = 20000;

   logic     clock = 0;
   logic     reset = 1;
   logic     req_valid = 0;
   logic     req_ready;
   fpve_pkg::req_type  req_data = '0;
   logic     rsp_valid;
   logic     rsp_ready = 0;
   fpve_pkg::rsp_type  rsp_data;
   logic     csr_valid = 0;
   logic     csr_ready;
   logic [1:0]  csr_index = fpve_pkg::REG_K_VEL;
   logic [23:0] csr_data = '0;
   int       fail_count, pending_count;
   int       send_idle_pct = 0, recv_idle_pct = 0;
   bit       recv_hold = 0;
   int       quiet_cycles = 0;
   logic [47:0] track_time = 0;
   longint   track_pos [3];

   always #6 clock = ~clock;

   filtered_pose_velocity_estimator_core dut (.*);

   fpve_checker checker_i (.*);

   // response side stalls
   always @(posedge clock) begin
      if (reset) rsp_ready <= 0;
      else rsp_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
   end

   // watchdog on cycles with no traffic
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > IDLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // the block does not take a new request until its sequencer is back in idle,
   // so the idle wait after the handshake costs nothing
   task automatic send_pose(input fpve_pkg::req_type r);
      while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      req_valid <= 1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      req_valid <= 0;
      @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   task automatic drain;
      while (pending_count != 0) @(posedge clock);
      repeat (500) @(posedge clock);
   endtask

   task automatic set_filter(input logic [15:0] kv, input logic [15:0] kr,
                             input logic [23:0] lo, input logic [23:0] hi);
      drain();
      write_reg(fpve_pkg::REG_K_VEL, 24'(kv));
      write_reg(fpve_pkg::REG_K_RATE, 24'(kr));
      write_reg(fpve_pkg::REG_MIN_GAP, lo);
      write_reg(fpve_pkg::REG_MAX_GAP, hi);
   endtask

   function automatic logic [31:0] rand_quat_part();
      case ($urandom_range(3))
         0: return $urandom;
         1: return 32'h4000_0000 + $urandom_range(65535) - 32768;
         2: return 32'hC000_0000 + $urandom_range(65535) - 32768;
         default: return 32'(int'($urandom_range(1 << 24)) - (1 << 23));
      endcase
   endfunction

   // pose following a smooth track, sometimes broken
   function automatic fpve_pkg::req_type track_pose();
      fpve_pkg::req_type r;
      int kind;
      kind = $urandom_range(99);
      if (kind < 80) track_time += $urandom_range(5000, 50);
      else if (kind < 85) track_time -= $urandom_range(1000);
      else if (kind < 90) track_time = 48'({$urandom, $urandom});
      else if (kind < 93) track_time = 0;
      else track_time += $urandom_range(3000000);
      for (int i = 0; i < 3; i++)
         track_pos[i] = (kind < 95) ? track_pos[i] + int'($urandom_range(200000)) - 100000
                                    : longint'(int'($urandom));
      r.time_us = track_time;
      r.pos_x = track_pos[0][31:0]; r.pos_y = track_pos[1][31:0];
      r.pos_z = track_pos[2][31:0];
      r.quat_w = rand_quat_part(); r.quat_x = rand_quat_part();
      r.quat_y = rand_quat_part(); r.quat_z = rand_quat_part();
      return r;
   endfunction

   function automatic fpve_pkg::req_type pose(input logic [47:0] t, input logic [31:0] p,
                                              input logic [31:0] qw, input logic [31:0] qv);
      fpve_pkg::req_type r;
      r.time_us = t; r.pos_x = p; r.pos_y = ~p; r.pos_z = p >>> 3;
      r.quat_w = qw; r.quat_x = qv; r.quat_y = ~qv; r.quat_z = qv ^ 32'h5555_5555;
      return r;
   endfunction

   initial begin
      for (int i = 0; i < 3; i++) track_pos[i] = 0;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: unset time, first load, small and large gaps, extremes
      send_pose(pose(0, 32'h0001_0000, 32'h4000_0000, 0));
      send_pose(pose(1000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
      send_pose(pose(1000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
      send_pose(pose(900, 32'h0, 32'h4000_0000, 32'h0));
      send_pose(pose(999, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
      send_pose(pose(1099, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
      send_pose(pose(1199, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
      send_pose(pose(2001199, 32'h0, 32'h4000_0000, 32'h0));
      send_pose(pose(4001200, 32'h1234_5678, 32'h3FFF_0000, 32'h0010_0000));
      send_pose(pose(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_pose(pose(48'h0000_0000_0001, 32'h1, 32'h1, 32'h1));
      send_pose(pose(48'h0000_0000_0002, 32'h2, 32'h4000_0000, 32'h2));
      set_filter(16'hFFFF, 16'hFFFF, 24'd0, 24'hFF_FFFF);
      send_pose(pose(10, 32'h0000_1000, 32'h4000_0000, 32'h0));
      send_pose(pose(10 + 24'hFF_FFFF, 32'h7FFF_0000, 32'h2000_0000, 32'h2000_0000));
      send_pose(pose(48'hAAAA_AAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555));
      send_pose(pose(48'hAAAA_AAAA_AAAB, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA));
      set_filter(16'h8000, 16'h0001, 24'd500, 24'd400);
      send_pose(pose(100, 32'h1, 32'h4000_0000, 32'h0));
      send_pose(pose(550, 32'h2, 32'h4000_0000, 32'h1));

      // random tracks under several settings and idling patterns
      for (int phase = 0; phase < 6; phase++) begin
         case (phase % 3)
            0: begin send_idle_pct = 25; recv_idle_pct = 46; end
            1: begin send_idle_pct = 46; recv_idle_pct = 25; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         set_filter(16'($urandom), 16'($urandom), 24'($urandom_range(200)),
                    24'($urandom_range(6000000, 3000)));
         for (int n = 0; n < 200; n++) begin
            // long receiver hold-off while requests keep coming
            if (phase == 1 && n == 10) begin
               fork
                  begin
                     recv_hold = 1;
                     repeat (3000) @(posedge clock);
                     recv_hold = 0;
                  end
               join_none
            end
            // sender waits for all responses
            if (n == 100) while (pending_count != 0) @(posedge clock);
            send_pose(track_pose());
         end
      end
      set_filter(16'h0, 16'h0, 24'd100, 24'd2000000);

      if (fail_count == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

endmodule

// ----- filtered_pose_velocity_estimator_core.f -----
rtl/core/fpve_pkg.sv
rtl/core/fpve_div.sv
rtl/core/filtered_pose_velocity_estimator_core.sv
sim/fpve_checker.sv
sim/tb.sv
